FILE: sv/e2q_pkg.sv
// Package for the Euler-to-quaternion pipeline: CORDIC constants and arctangent table.
// Used by every module of the block; depends on nothing.
package e2q_pkg;
	localparam int CordicSteps = 30;
	localparam int QW = 34;          // Q2.30 plus headroom for the fold and the residual
	localparam logic signed [QW-1:0] PiQ30     = 34'sd3373259426;
	localparam logic signed [QW-1:0] HalfPiQ30 = 34'sd1686629713;
	localparam logic signed [QW-1:0] GainQ30   = 34'sd652032874;

	typedef logic signed [QW-1:0] q30_t;

	typedef struct packed {
		q30_t x;
		q30_t y;
		q30_t z;
	} rot_t;

	typedef struct packed {
		rot_t roll;
		rot_t pitch;
		rot_t yaw;
		logic flip_r;
		logic flip_p;
		logic flip_y;
	} cell_data_t;

	function automatic q30_t atan_q30(input int i);
		q30_t t;
		case (i)
			0: t = 34'sd843314857;
			1: t = 34'sd497837829;
			2: t = 34'sd263043837;
			3: t = 34'sd133525159;
			4: t = 34'sd67021687;
			5: t = 34'sd33543516;
			6: t = 34'sd16775851;
			7: t = 34'sd8388437;
			8: t = 34'sd4194283;
			9: t = 34'sd2097149;
			default: t = q30_t'(34'sd1 <<< (30 - i));
		endcase
		return t;
	endfunction
endpackage

FILE: sv/euler_to_quaternion.sv
// Top level: Euler roll/pitch/yaw (Q4.12) to unit quaternion (Q1.14) pipeline.
// Depends on e2q_pkg, e2q_cell, e2q_combine.
// Takes one beat per cycle while in_ready is high. The pipeline is 1 fold stage, 30 CORDIC
// cells and 3 combine stages from input beat to result beat. The whole pipeline advances
// together whenever the output register is empty or being drained, so ready is low
// exactly while a result waits at the output with out_ready low; the whole pipe then
// holds, empty slots included.
module euler_to_quaternion #(
	parameter int ANGLE_BITS     = 16,
	parameter int COMPONENT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [ANGLE_BITS-1:0]     roll_angle,
	input  logic signed [ANGLE_BITS-1:0]     pitch_angle,
	input  logic signed [ANGLE_BITS-1:0]     yaw_angle,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [COMPONENT_BITS-1:0] quat_x,
	output logic signed [COMPONENT_BITS-1:0] quat_y,
	output logic signed [COMPONENT_BITS-1:0] quat_z,
	output logic signed [COMPONENT_BITS-1:0] quat_w
);
	localparam int N = e2q_pkg::CordicSteps;

	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	function automatic e2q_pkg::q30_t to_q30(input logic signed [ANGLE_BITS-1:0] a);
		return e2q_pkg::q30_t'(a) <<< (33 - ANGLE_BITS);
	endfunction

	// half angle beyond +/- pi/2 is brought back by pi; sine and cosine flip later
	function automatic logic needs_fold(input e2q_pkg::q30_t z);
		return (z > e2q_pkg::HalfPiQ30) || (z < -e2q_pkg::HalfPiQ30);
	endfunction

	function automatic e2q_pkg::rot_t fold(input e2q_pkg::q30_t z);
		e2q_pkg::rot_t r;
		r.x = e2q_pkg::GainQ30;
		r.y = '0;
		if (z > e2q_pkg::HalfPiQ30) r.z = z - e2q_pkg::PiQ30;
		else if (z < -e2q_pkg::HalfPiQ30) r.z = z + e2q_pkg::PiQ30;
		else r.z = z;
		return r;
	endfunction

	e2q_pkg::cell_data_t d0_s1;
	logic vld0_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			d0_s1.roll   <= fold(to_q30(roll_angle));
			d0_s1.pitch  <= fold(to_q30(pitch_angle));
			d0_s1.yaw    <= fold(to_q30(yaw_angle));
			d0_s1.flip_r <= needs_fold(to_q30(roll_angle));
			d0_s1.flip_p <= needs_fold(to_q30(pitch_angle));
			d0_s1.flip_y <= needs_fold(to_q30(yaw_angle));
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld0_s1 <= 1'b0;
		else if (en) vld0_s1 <= in_valid;
	end

	e2q_pkg::cell_data_t chain_d [N+1];
	logic chain_v [N+1];
	assign chain_d[0] = d0_s1;
	assign chain_v[0] = vld0_s1;

	for (genvar i = 0; i < N; i++) begin : g_cell
		e2q_cell #(.STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(chain_v[i]), .d_in(chain_d[i]),
			.vld_out(chain_v[i+1]), .d_out(chain_d[i+1])
		);
	end

	e2q_combine #(.COMPONENT_BITS(COMPONENT_BITS)) u_combine (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(chain_v[N]), .d_in(chain_d[N]),
		.vld_out(out_valid),
		.qx(quat_x), .qy(quat_y), .qz(quat_z), .qw(quat_w)
	);
endmodule

FILE: sv/e2q_cell.sv
// One CORDIC micro-rotation for all three angles, one register stage.
// Depends on e2q_pkg.
module e2q_cell #(
	parameter int STEP = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_in,
	input  e2q_pkg::cell_data_t   d_in,
	output logic                  vld_out,
	output e2q_pkg::cell_data_t   d_out
);
	function automatic e2q_pkg::rot_t rotate(input e2q_pkg::rot_t r);
		e2q_pkg::rot_t o;
		e2q_pkg::q30_t dx;
		e2q_pkg::q30_t dy;
		dx = r.y >>> STEP;
		dy = r.x >>> STEP;
		if (!r.z[e2q_pkg::QW-1]) begin
			o.x = r.x - dx;
			o.y = r.y + dy;
			o.z = r.z - e2q_pkg::atan_q30(STEP);
		end else begin
			o.x = r.x + dx;
			o.y = r.y - dy;
			o.z = r.z + e2q_pkg::atan_q30(STEP);
		end
		return o;
	endfunction

	e2q_pkg::cell_data_t d_q;
	logic vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q.roll   <= rotate(d_in.roll);
			d_q.pitch  <= rotate(d_in.pitch);
			d_q.yaw    <= rotate(d_in.yaw);
			d_q.flip_r <= d_in.flip_r;
			d_q.flip_p <= d_in.flip_p;
			d_q.flip_y <= d_in.flip_y;
		end
	end

	assign vld_out = vld_q;
	assign d_out   = d_q;
endmodule

FILE: sv/e2q_combine.sv
// Quaternion combine: sign fix, triple products in two multiply stages, sum, round, clamp.
// Depends on e2q_pkg.
module e2q_combine #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_in,
	input  e2q_pkg::cell_data_t         d_in,
	output logic                        vld_out,
	output logic signed [COMPONENT_BITS-1:0] qx,
	output logic signed [COMPONENT_BITS-1:0] qy,
	output logic signed [COMPONENT_BITS-1:0] qz,
	output logic signed [COMPONENT_BITS-1:0] qw
);
	localparam int PW = 2 * e2q_pkg::QW;
	localparam int SH = 32 - COMPONENT_BITS;
	localparam int OW = e2q_pkg::QW + 2;

	function automatic e2q_pkg::q30_t rnd30(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = (p + (PW'(1) <<< 29)) >>> 30;
		return e2q_pkg::q30_t'(t);
	endfunction

	function automatic e2q_pkg::q30_t neg_if(input e2q_pkg::q30_t v, input logic f);
		return f ? -v : v;
	endfunction

	e2q_pkg::q30_t sr, cr, sp, cp, sy, cy;
	assign sr = neg_if(d_in.roll.y,  d_in.flip_r);
	assign cr = neg_if(d_in.roll.x,  d_in.flip_r);
	assign sp = neg_if(d_in.pitch.y, d_in.flip_p);
	assign cp = neg_if(d_in.pitch.x, d_in.flip_p);
	assign sy = neg_if(d_in.yaw.y,   d_in.flip_y);
	assign cy = neg_if(d_in.yaw.x,   d_in.flip_y);

	// stage 1: pair products of roll and pitch terms
	e2q_pkg::q30_t srcp_s1, crsp_s1, crcp_s1, srsp_s1, sy_s1, cy_s1;
	logic vld_s1, vld_s2, vld_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			srcp_s1 <= rnd30(PW'(sr) * PW'(cp));
			crsp_s1 <= rnd30(PW'(cr) * PW'(sp));
			crcp_s1 <= rnd30(PW'(cr) * PW'(cp));
			srsp_s1 <= rnd30(PW'(sr) * PW'(sp));
			sy_s1   <= sy;
			cy_s1   <= cy;
		end
	end

	// stage 2: products with yaw terms
	e2q_pkg::q30_t p_s2 [8];
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= rnd30(PW'(srcp_s1) * PW'(cy_s1));
			p_s2[1] <= rnd30(PW'(crsp_s1) * PW'(sy_s1));
			p_s2[2] <= rnd30(PW'(crsp_s1) * PW'(cy_s1));
			p_s2[3] <= rnd30(PW'(srcp_s1) * PW'(sy_s1));
			p_s2[4] <= rnd30(PW'(crcp_s1) * PW'(sy_s1));
			p_s2[5] <= rnd30(PW'(srsp_s1) * PW'(cy_s1));
			p_s2[6] <= rnd30(PW'(crcp_s1) * PW'(cy_s1));
			p_s2[7] <= rnd30(PW'(srsp_s1) * PW'(sy_s1));
		end
	end

	function automatic logic signed [COMPONENT_BITS-1:0] to_comp(
		input logic signed [OW-1:0] s);
		logic signed [OW-1:0] v;
		logic signed [OW-1:0] lim;
		lim = OW'(1) <<< (COMPONENT_BITS - 2);
		if (SH == 0) v = s;
		else v = (s + (OW'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v[COMPONENT_BITS-1:0];
	endfunction

	logic signed [OW-1:0] sx, sy2, sz, sw;
	assign sx  = OW'(p_s2[0]) - OW'(p_s2[1]);
	assign sy2 = OW'(p_s2[2]) + OW'(p_s2[3]);
	assign sz  = OW'(p_s2[4]) - OW'(p_s2[5]);
	assign sw  = OW'(p_s2[6]) + OW'(p_s2[7]);

	logic signed [COMPONENT_BITS-1:0] qx_s3, qy_s3, qz_s3, qw_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			qx_s3 <= to_comp(sx);
			qy_s3 <= to_comp(sy2);
			qz_s3 <= to_comp(sz);
			qw_s3 <= to_comp(sw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign vld_out = vld_s3;
	assign qx = qx_s3;
	assign qy = qy_s3;
	assign qz = qz_s3;
	assign qw = qw_s3;
endmodule

FILE: sv/e2q_checker.sv
// Port-level checks for euler_to_quaternion, bound to the top level.
// Depends on nothing but the top level's ports.
module e2q_checker #(
	parameter int COMPONENT_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [COMPONENT_BITS-1:0] quat_x,
	input logic signed [COMPONENT_BITS-1:0] quat_w
);
	localparam logic signed [COMPONENT_BITS-1:0] One = COMPONENT_BITS'(1) <<< (COMPONENT_BITS-2);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_x) && $stable(quat_w))
		else $error("result beat changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output drain");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quat_w <= One && quat_w >= -One && quat_x <= One && quat_x >= -One)
		else $error("component outside unit range");
endmodule

bind euler_to_quaternion e2q_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_e2q_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .quat_x(quat_x), .quat_w(quat_w)
);
